### design/homogeneous_point_transform_assert.svh
// ---------------------------------------------------------------------------
// homogeneous point transform assertion macros
// shared concurrent assertion forms, clocked on aclk
// ---------------------------------------------------------------------------
`ifndef HOMOGENEOUS_POINT_TRANSFORM_ASSERT_SVH
`define HOMOGENEOUS_POINT_TRANSFORM_ASSERT_SVH

// checked only outside reset
`define HPT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// checked in every cycle, reset included
`define HPT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

### design/hpt_pkg.sv
// ---------------------------------------------------------------------------
// hpt_pkg
// widths, payload types and reset values of the 4x4 point transform
// ---------------------------------------------------------------------------
package hpt_pkg;

    localparam int LANES     = 4;
    localparam int DATA_W    = 32;
    localparam int FRAC_BITS = 16;
    localparam int NUM_REGS  = 8;
    localparam int REG_W     = 64;
    localparam int ADDR_W    = $clog2(NUM_REGS * (REG_W / 8));
    localparam int IDX_W     = $clog2(NUM_REGS);
    localparam int IDX_LSB   = $clog2(REG_W / 8);

    localparam int PROD_W  = 2 * DATA_W;
    localparam int PAIR_W  = PROD_W + 1;
    localparam int SUM_W   = PROD_W + 2;
    localparam int SHIFT_W = SUM_W - FRAC_BITS;

    localparam logic [DATA_W-1:0] ONE_FX  = DATA_W'(1) << FRAC_BITS;
    localparam logic [DATA_W-1:0] MAX_FX  = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] MIN_FX  = {1'b1, {(DATA_W-1){1'b0}}};

    typedef logic [LANES-1:0][DATA_W-1:0] vec_t;
    typedef logic [REG_W-1:0]             cfg_word_t;
    typedef logic [SUM_W-1:0]             sum_t;
    typedef sum_t [LANES-1:0]             sum_vec_t;
    typedef vec_t [LANES-1:0]             coef_mat_t;

    // load enables of the four pipeline stages
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } pipe_en_t;

    // identity matrix, two coefficients per register
    function automatic cfg_word_t cfg_reset_value(input int idx);
        cfg_word_t word;
        int        row;
        int        col;
        word = '0;
        row  = idx / 2;
        for (int h = 0; h < 2; h++) begin
            col = 2 * (idx % 2) + h;
            if (col == row) begin
                word[h*DATA_W +: DATA_W] = ONE_FX;
            end
        end
        return word;
    endfunction

endpackage

### design/hpt_regs.sv
// ---------------------------------------------------------------------------
// hpt_regs
// coefficient register file behind the apb port
// ---------------------------------------------------------------------------
module hpt_regs
    import hpt_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [REG_W-1:0]  pwdata,
    output logic [REG_W-1:0]  prdata,
    output logic              pready,
    output coef_mat_t         coef
);

    cfg_word_t        cfg_reg [NUM_REGS];
    logic [IDX_W-1:0] idx;
    logic             wr_en;

    assign pready = 1'b1;
    assign idx    = paddr[ADDR_W-1:IDX_LSB];
    assign wr_en  = psel && penable && pwrite && pready;
    assign prdata = cfg_reg[idx];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                cfg_reg[i] <= cfg_reset_value(i);
            end
        end else if (wr_en) begin
            cfg_reg[idx] <= pwdata;
        end
    end

    // row r: cols 0,1 in register 2r, cols 2,3 in register 2r+1
    for (genvar r = 0; r < LANES; r++) begin : g_row
        for (genvar c = 0; c < LANES; c++) begin : g_col
            assign coef[r][c] = cfg_reg[2*r + c/2][(c%2)*DATA_W +: DATA_W];
        end
    end

endmodule

### design/hpt_lane.sv
// ---------------------------------------------------------------------------
// hpt_lane
// one matrix row dotted with the tuple, exact sum over three stages
// ---------------------------------------------------------------------------
module hpt_lane
    import hpt_pkg::*;
(
    input  logic     aclk,
    input  pipe_en_t en,
    input  vec_t     coef_row,
    input  vec_t     tuple,
    output sum_t     sum
);

    logic signed [PROD_W-1:0] prod_reg [LANES];
    logic signed [PROD_W-1:0] prod_next [LANES];
    logic signed [PAIR_W-1:0] pair_reg [2];
    logic signed [PAIR_W-1:0] pair_next [2];
    logic signed [SUM_W-1:0]  sum_reg;
    logic signed [SUM_W-1:0]  sum_next;

    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            prod_next[k] = $signed(coef_row[k]) * $signed(tuple[k]);
        end
        for (int j = 0; j < 2; j++) begin
            pair_next[j] = PAIR_W'(prod_reg[2*j]) + PAIR_W'(prod_reg[2*j+1]);
        end
        sum_next = SUM_W'(pair_reg[0]) + SUM_W'(pair_reg[1]);
    end

    always_ff @(posedge aclk) begin
        if (en.s1) begin
            prod_reg <= prod_next;
        end
        if (en.s2) begin
            pair_reg <= pair_next;
        end
        if (en.s3) begin
            sum_reg <= sum_next;
        end
    end

    assign sum = sum_reg;

endmodule

### design/hpt_merge.sv
// ---------------------------------------------------------------------------
// hpt_merge
// scales and clamps the four row sums, folds clamp flags into one
// ---------------------------------------------------------------------------
module hpt_merge
    import hpt_pkg::*;
(
    input  logic     aclk,
    input  pipe_en_t en,
    input  sum_vec_t sums,
    output vec_t     result,
    output logic     saturated
);

    vec_t             result_reg;
    vec_t             result_next;
    logic             sat_reg;
    logic             sat_next;
    logic [LANES-1:0] lane_sat;

    always_comb begin
        logic [SHIFT_W-1:0]      shifted;
        logic [SHIFT_W-DATA_W:0] upper;
        for (int k = 0; k < LANES; k++) begin
            // arithmetic shift: drop the fraction bits of the exact sum
            shifted     = sums[k][SUM_W-1:FRAC_BITS];
            upper       = shifted[SHIFT_W-1:DATA_W-1];
            lane_sat[k] = (|upper) && !(&upper);
            if (lane_sat[k]) begin
                result_next[k] = shifted[SHIFT_W-1] ? MIN_FX : MAX_FX;
            end else begin
                result_next[k] = shifted[DATA_W-1:0];
            end
        end
        sat_next = |lane_sat;
    end

    always_ff @(posedge aclk) begin
        if (en.s4) begin
            result_reg <= result_next;
            sat_reg    <= sat_next;
        end
    end

    assign result    = result_reg;
    assign saturated = sat_reg;

endmodule

### design/homogeneous_point_transform.sv
// ---------------------------------------------------------------------------
// homogeneous_point_transform
// 4x4 fixed point matrix times a streamed (x,y,z,w) tuple
// ---------------------------------------------------------------------------
// Each item carries a signed Q16.16 tuple (x,y,z,w); the result item carries
// the four row dot products, floored after the 16-bit shift and clamped to
// signed 32 bits, plus a flag set when any lane was clamped. Products are
// summed exactly, so no intermediate overflow occurs. The sixteen coefficients
// sit two per 64-bit register (row r cols 0/1 at byte 16r, cols 2/3 at byte
// 16r+8, lower column in the low half) and reset to the identity matrix.
// Throughput is one item per clock while m_tready keeps the output stage from
// holding. An item passes through the four register stages multiply, pair
// add, final add, clamp.
// Four row lanes run side by side, each with four 32x32 multipliers.
// Every stage has its own valid bit, so bubbles close up and a new item is
// accepted while a finished result waits on m_tready, as long as some stage
// is free. Coefficients may only be rewritten while no item is in flight.
// ---------------------------------------------------------------------------
`include "homogeneous_point_transform_assert.svh"

module homogeneous_point_transform
    import hpt_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    // input tuple: x [31:0], y [63:32], z [95:64], w [127:96]
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [LANES*DATA_W-1:0]    s_tdata,
    // result: out_x [31:0], out_y [63:32], out_z [95:64], out_w [127:96]
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [LANES*DATA_W-1:0]    m_tdata,
    // result flags: saturated [0]
    output logic                       m_tuser,
    // coefficient register port
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ADDR_W-1:0]          paddr,
    input  logic [REG_W-1:0]           pwdata,
    output logic [REG_W-1:0]           prdata,
    output logic                       pready
);

    coef_mat_t coef;
    sum_vec_t  sums;
    vec_t      result;
    pipe_en_t  en;

    // per-stage valid bits, stage 4 is the output register
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy1, rdy2, rdy3, rdy4;

    // lanes of the current result that hold a clamp value
    logic [LANES-1:0] clamp_hit;

    // a stage can load when empty or when its contents move on this cycle
    assign rdy4 = !v4_reg || m_tready;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;

    assign en.s1 = rdy1;
    assign en.s2 = rdy2;
    assign en.s3 = rdy3;
    assign en.s4 = rdy4;

    assign s_tready = rdy1;
    assign m_tvalid = v4_reg;
    assign m_tdata  = result;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (rdy1) begin
                v1_reg <= s_tvalid;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
            if (rdy3) begin
                v3_reg <= v2_reg;
            end
            if (rdy4) begin
                v4_reg <= v3_reg;
            end
        end
    end

    hpt_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .coef    (coef)
    );

    // one lane per matrix row
    for (genvar r = 0; r < LANES; r++) begin : g_lane
        hpt_lane u_lane (
            .aclk     (aclk),
            .en       (en),
            .coef_row (coef[r]),
            .tuple    (vec_t'(s_tdata)),
            .sum      (sums[r])
        );
    end

    hpt_merge u_merge (
        .aclk      (aclk),
        .en        (en),
        .sums      (sums),
        .result    (result),
        .saturated (m_tuser)
    );

    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            clamp_hit[k] = (result[k] == MAX_FX) || (result[k] == MIN_FX);
        end
    end

    // input stalls only when every stage is occupied
    `HPT_ASSERT(a_stall_full, !s_tready |-> &{v1_reg, v2_reg, v3_reg, v4_reg}, "stall with a free stage")
    // an accepted item lands in the first stage
    `HPT_ASSERT(a_accept_fill, (s_tvalid && s_tready) |=> v1_reg, "accepted item lost at stage 1")
    // a flagged result holds a clamp value in some lane
    `HPT_ASSERT(a_sat_value, (m_tvalid && m_tuser) |-> (|clamp_hit), "saturated without a clamp")
    // reset empties the output stage
    `HPT_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_tvalid, "result valid right after reset")

endmodule
